>>> rtl/period_tachometer_avg_timeout_macros.svh
// assertion macros for the period tachometer block
// used by the top level; expects clk and rst_n in the including scope
`ifndef PERIOD_TACHOMETER_AVG_TIMEOUT_MACROS_SVH
`define PERIOD_TACHOMETER_AVG_TIMEOUT_MACROS_SVH

// same-cycle implication, disabled during reset
`define PTA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define PTA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/pta_pkg.sv
// shared constants and types for the period tachometer block
// no dependencies; imported by the divider and the top level
`timescale 1ns / 1ps
`default_nettype none

package pta_pkg;

    // averaging ring
    localparam int AVG_DEPTH = 8;
    localparam int SLOT_W    = $clog2(AVG_DEPTH);

    // field widths
    localparam int CLK_W     = 27;
    localparam int TMO_W     = 32;
    localparam int CAP_W     = 32;
    localparam int RAW_W     = 35;
    localparam int AVG_OUT_W = 38;
    localparam int FRAC_W    = 8;
    localparam int CMD_W     = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;

    // divider widths: dividend is clock_hz * AVG_DEPTH * 256
    localparam int MULT_W = $clog2(AVG_DEPTH + 1);
    localparam int NUM_W  = CLK_W + MULT_W + FRAC_W;
    localparam int SUM_W  = CAP_W + SLOT_W;
    localparam int DEN_W  = SUM_W;
    localparam int SAT_W  = (NUM_W > AVG_OUT_W) ? NUM_W : AVG_OUT_W;

    localparam logic [NUM_W-1:0]     AVG_MULT = NUM_W'(AVG_DEPTH);
    localparam logic [AVG_OUT_W-1:0] AVG_MAX  = {AVG_OUT_W{1'b1}};

    // command codes
    localparam logic [CMD_W-1:0] CMD_EDGE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CLOCK_HZ = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 2'd1;

    // register reset values
    localparam logic [CLK_W-1:0] CLOCK_HZ_RESET = 27'd80000000;
    localparam logic [TMO_W-1:0] TIMEOUT_RESET  = 32'd40000000;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

endpackage

`default_nettype wire

>>> rtl/pta_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module pta_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/pta_div.sv
// iterative restoring divider, one quotient bit per cycle
// depends on pta_pkg for operand widths
`timescale 1ns / 1ps
`default_nettype none

module pta_div
    import pta_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  done,
    output logic      [NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_W - 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W:0]   rem_shift;
    logic [DEN_W:0]   diff;
    logic             take;

    // one trial subtraction
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[NUM_W-1]};
        diff      = rem_shift - {1'b0, den_reg};
        take      = !diff[DEN_W];
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg  <= cnt_reg + CNT_W'(1);
            busy_reg <= (cnt_reg != CNT_LAST);
            done_reg <= (cnt_reg == CNT_LAST);
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= take ? diff[DEN_W-1:0] : rem_shift[DEN_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], take};
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

`default_nettype wire

>>> rtl/period_tachometer_avg_timeout.sv
// top level of the period tachometer with moving average and timeout
// depends on pta_pkg, pta_ram, pta_div and the assertion macro header
//
// Usage:
//   Input channel (in_valid / in_stall) carries cmd and capture_count. An edge
//   transaction turns the captured down-count into a period, updates the
//   period ring held in a small ram and its running sum, then runs two
//   iterative dividers side by side for the raw and averaged frequency.
//   Tick transactions count the timeout down; clear drops the measurement.
//   Every transaction gives one result transaction on out_valid / out_stall
//   with alive, raw_freq and avg_freq.
//   An edge with a nonzero period goes through S_READ, then S_DIV, where it
//   waits on the one-bit-per-cycle dividers, then S_DONE; all other commands
//   go straight to S_DONE. One transaction is in work at a time; the next one
//   is taken as soon as the previous result sits in the output register.
//   A stalled result holds in the output register; a finished item waits
//   for it to drain before loading, and no new input is taken meanwhile.
//   Reset clears the ring valid bits, capture, sum, flags and frequencies and
//   loads the register defaults; no clearing pass is needed.
//   Configuration (cfg_valid / cfg_ready) is always ready: index 0 clock_hz,
//   index 1 timeout_ticks, other indexes are ignored.
`timescale 1ns / 1ps
`default_nettype none
`include "period_tachometer_avg_timeout_macros.svh"

module period_tachometer_avg_timeout
    import pta_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [CMD_W-1:0]     cmd,
    input  wire logic [CAP_W-1:0]     capture_count,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic                      alive,
    output logic      [RAW_W-1:0]     raw_freq,
    output logic      [AVG_OUT_W-1:0] avg_freq,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_data
);

    state_t state_reg;
    state_t state_next;

    logic [CLK_W-1:0]     clock_hz_reg;
    logic [TMO_W-1:0]     timeout_ticks_reg;
    logic [CAP_W-1:0]     last_capture_reg;
    logic [CAP_W-1:0]     period_reg;
    logic [SUM_W-1:0]     sum_reg;
    logic [SLOT_W-1:0]    slot_reg;
    logic [AVG_DEPTH-1:0] ring_valid_reg;
    logic                 alive_reg;
    logic [RAW_W-1:0]     raw_held_reg;
    logic [AVG_OUT_W-1:0] avg_held_reg;
    logic [TMO_W-1:0]     timeout_left_reg;
    logic                 out_valid_reg;
    logic                 out_alive_reg;
    logic [RAW_W-1:0]     out_raw_reg;
    logic [AVG_OUT_W-1:0] out_avg_reg;

    logic             in_accept;
    logic             out_load;
    logic [CAP_W-1:0] period_new;
    logic             ram_re;
    logic [CAP_W-1:0] ram_rdata;
    logic [CAP_W-1:0] old_period;
    logic [SUM_W-1:0] sum_new;
    logic             div_start;
    logic [NUM_W-1:0] raw_num;
    logic [NUM_W-1:0] avg_num;
    logic             raw_done;
    logic             avg_done;
    logic [NUM_W-1:0] raw_q;
    logic [NUM_W-1:0] avg_q;

    // handshakes
    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);
    assign cfg_ready = 1'b1;

    // period and ring read-modify-write
    assign period_new = last_capture_reg - capture_count;
    assign ram_re     = in_accept && (cmd == CMD_EDGE) && (period_new != '0);
    assign old_period = ring_valid_reg[slot_reg] ? ram_rdata : '0;
    assign sum_new    = sum_reg - SUM_W'(old_period) + SUM_W'(period_reg);
    assign div_start  = (state_reg == S_READ);

    // divider operands
    assign raw_num = NUM_W'({clock_hz_reg, FRAC_W'(0)});
    assign avg_num = (NUM_W'(clock_hz_reg) * AVG_MULT) << FRAC_W;

    pta_ram #(
        .WIDTH (CAP_W),
        .DEPTH (AVG_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (div_start),
        .waddr (slot_reg),
        .wdata (period_reg),
        .re    (ram_re),
        .raddr (slot_reg),
        .rdata (ram_rdata)
    );

    pta_div u_div_raw (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (raw_num),
        .den   (DEN_W'(period_reg)),
        .done  (raw_done),
        .quot  (raw_q)
    );

    pta_div u_div_avg (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (avg_num),
        .den   (sum_new),
        .done  (avg_done),
        .quot  (avg_q)
    );

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ram_re ? S_READ : S_DONE;
                end
            end
            S_READ:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (raw_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // measurement state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            clock_hz_reg      <= CLOCK_HZ_RESET;
            timeout_ticks_reg <= TIMEOUT_RESET;
            last_capture_reg  <= '0;
            sum_reg           <= '0;
            slot_reg          <= '0;
            ring_valid_reg    <= '0;
            alive_reg         <= 1'b0;
            raw_held_reg      <= '0;
            avg_held_reg      <= '0;
            timeout_left_reg  <= TIMEOUT_RESET;
        end
        else
        begin
            state_reg <= state_next;

            // register writes
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_CLOCK_HZ)
                begin
                    clock_hz_reg <= cfg_data[CLK_W-1:0];
                end
                else if (cfg_index == REG_TIMEOUT)
                begin
                    timeout_ticks_reg <= cfg_data[TMO_W-1:0];
                end
            end

            // command dispatch
            if (in_accept)
            begin
                case (cmd)
                    CMD_EDGE:
                    begin
                        last_capture_reg <= capture_count;
                    end
                    CMD_TICK:
                    begin
                        if (timeout_left_reg <= TMO_W'(1))
                        begin
                            alive_reg        <= 1'b0;
                            raw_held_reg     <= '0;
                            avg_held_reg     <= '0;
                            timeout_left_reg <= timeout_ticks_reg;
                        end
                        else
                        begin
                            timeout_left_reg <= timeout_left_reg - TMO_W'(1);
                        end
                    end
                    CMD_CLEAR:
                    begin
                        alive_reg    <= 1'b0;
                        raw_held_reg <= '0;
                        avg_held_reg <= '0;
                    end
                    default:
                    begin
                        alive_reg <= alive_reg;
                    end
                endcase
            end

            // ring write-back and sum update
            if (state_reg == S_READ)
            begin
                sum_reg                  <= sum_new;
                ring_valid_reg[slot_reg] <= 1'b1;
                slot_reg <= (slot_reg == SLOT_W'(AVG_DEPTH - 1)) ? '0
                                                                 : slot_reg + SLOT_W'(1);
                alive_reg        <= 1'b1;
                timeout_left_reg <= timeout_ticks_reg;
            end

            // frequency results
            if ((state_reg == S_DIV) && raw_done)
            begin
                raw_held_reg <= RAW_W'(raw_q);
                if (sum_reg != '0)
                begin
                    if (SAT_W'(avg_q) > SAT_W'(AVG_MAX))
                    begin
                        avg_held_reg <= AVG_MAX;
                    end
                    else
                    begin
                        avg_held_reg <= AVG_OUT_W'(avg_q);
                    end
                end
            end
        end
    end

    // captured period for the ring update
    always_ff @(posedge clk)
    begin
        if (ram_re)
        begin
            period_reg <= period_new;
        end
    end

    // output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_alive_reg <= alive_reg;
            out_raw_reg   <= raw_held_reg;
            out_avg_reg   <= avg_held_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign alive     = out_alive_reg;
    assign raw_freq  = out_raw_reg;
    assign avg_freq  = out_avg_reg;

    // checks
    `PTA_ASSERT_NOW(a_div_done_in_div, raw_done, state_reg == S_DIV, "divider done outside wait")
    `PTA_ASSERT_NOW(a_div_in_step, raw_done, avg_done, "raw and average dividers out of step")
    `PTA_ASSERT_NOW(a_alive_from_edge, $rose(alive_reg), $past(state_reg == S_READ),
        "alive set without an edge update")
    `PTA_ASSERT_NEXT(a_edge_reads_ring, ram_re, state_reg == S_READ,
        "edge transaction did not read the ring")

endmodule

`default_nettype wire
